/* design/sdq_pkg.sv */
// Shared types and codes for the sortable double-ended queue.
// Used by sdq_cell and by the sortable_double_ended_queue top level.
`default_nettype none

package sdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int ACTION_W      = 3;
    localparam int FILL_W        = 5;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SORT       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN_FRONT,
        OP_LOAD_BACK,
        OP_SHIFT_OUT_FRONT,
        OP_SORT_STEP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } sdq_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_SORT
    } sdq_state_t;

endpackage

`default_nettype wire

/* design/sdq_cell.sv */
// One storage cell of the queue row: holds a single entry and trades it with its neighbors.
// Depends on sdq_pkg for the control struct and cell operation codes.
`default_nettype none

module sdq_cell #(
    parameter int DEPTH = sdq_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  wire                                   aclk,
    input  wire sdq_pkg::sdq_ctrl_t               ctrl,
    input  wire [$clog2(DEPTH+1)-1:0]             count,
    input  wire signed [sdq_pkg::WORD_W-1:0]      push_value,
    input  wire signed [sdq_pkg::WORD_W-1:0]      left_data,
    input  wire signed [sdq_pkg::WORD_W-1:0]      right_data,
    output logic signed [sdq_pkg::WORD_W-1:0]     data
);
    import sdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);
    localparam logic          IDX_LSB = 1'(IDX % 2);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     is_lower;
    logic                     is_upper;

    assign is_lower = (IDX_LSB == ctrl.phase) && (IDX_P1 < count);
    assign is_upper = (IDX_LSB != ctrl.phase) && (IDX != 0) && (IDX_C < count);

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            OP_SHIFT_IN_FRONT: begin
                data_next = left_data;
            end
            OP_LOAD_BACK: begin
                if (count == IDX_C) begin
                    data_next = push_value;
                end
            end
            OP_SHIFT_OUT_FRONT: begin
                data_next = right_data;
            end
            OP_SORT_STEP: begin
                if (is_lower && (data_reg > right_data)) begin
                    data_next = right_data;
                end else if (is_upper && (left_data > data_reg)) begin
                    data_next = left_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* design/sortable_double_ended_queue.sv */
// Bounded double-ended queue of signed words held in a row of shifting cells,
// with an in-place ascending sort. The entry at the front always sits in cell 0;
// push and pop items flow at one item per cycle while the result side keeps up,
// each posting its result via the pending flag into the output register. When
// sorting is enabled, a sort item runs an odd-even transposition sort over the
// cell row, one neighbor-exchange pass per cycle, taking no input meanwhile; after
// the last pass it sets the pending flag, and the result loads once output is free.
// Depends on sdq_pkg and sdq_cell.
`default_nettype none

module sortable_double_ended_queue #(
    parameter int DEPTH = sdq_pkg::DEPTH_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_wdata,     // sort_enable
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,       // value[31:0]
    input  wire  [2:0]  s_tuser,       // action[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata        // front_value[31:0], back_value[63:32],
                                       // fill_count[68:64], is_empty[69], status[71:70]
);
    import sdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);
    localparam int PW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PASS  = PW'(DEPTH - 1);

    sdq_state_t               state_reg, state_next;
    sdq_ctrl_t                ctrl;
    logic [CW-1:0]            count_reg, count_next;
    logic [PW-1:0]            pass_reg, pass_next;
    status_t                  status_reg, status_next;
    logic                     pend_reg, pend_next;
    logic                     sort_en_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [71:0]              m_data_reg;

    logic                     accept;
    logic                     cap;
    logic                     is_full;
    logic                     is_empty_q;
    action_t                  act;

    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] front_val;
    logic signed [WORD_W-1:0] back_val;
    logic [CW+FILL_W-1:0]     count_ext;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [WORD_W-1:0] left_d;
            logic signed [WORD_W-1:0] right_d;
            if (gi == 0) begin : g_first
                assign left_d = $signed(s_tdata);
            end else begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_d = cell_data[gi];
            end else begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            sdq_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .push_value ($signed(s_tdata)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    assign cap        = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready   = (state_reg == S_IDLE) && (!pend_reg || cap);
    assign accept     = s_tvalid && s_tready;
    assign act        = action_t'(s_tuser);
    assign is_full    = (count_reg == FULL_COUNT);
    assign is_empty_q = (count_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && (act == ACT_SORT) && sort_en_reg) begin
                    state_next = S_SORT;
                end
            end
            S_SORT: begin
                if (pass_reg == LAST_PASS) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl.op     = OP_HOLD;
        ctrl.phase  = pass_reg[0];
        count_next  = count_reg;
        status_next = status_reg;
        pend_next   = pend_reg && !cap;
        pass_next   = pass_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pend_next   = 1'b1;
                    status_next = STAT_OK;
                    pass_next   = '0;
                    case (act)
                        ACT_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = STAT_OVERFLOW;
                            end else begin
                                ctrl.op    = OP_SHIFT_IN_FRONT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = STAT_OVERFLOW;
                            end else begin
                                ctrl.op    = OP_LOAD_BACK;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (is_empty_q) begin
                                status_next = STAT_UNDERFLOW;
                            end else begin
                                ctrl.op    = OP_SHIFT_OUT_FRONT;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (is_empty_q) begin
                                status_next = STAT_UNDERFLOW;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_SORT: begin
                            if (sort_en_reg) begin
                                pend_next = 1'b0;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SORT: begin
                ctrl.op   = OP_SORT_STEP;
                pass_next = pass_reg + 1'b1;
                if (pass_reg == LAST_PASS) begin
                    pend_next = 1'b1;
                end
            end
            default: begin
                ctrl.op = OP_HOLD;
            end
        endcase
    end

    assign front_val = is_empty_q ? '0 : cell_data[0];

    always_comb begin
        back_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (count_reg == CW'(k + 1)) begin
                back_val = back_val | cell_data[k];
            end
        end
    end

    assign count_ext    = {{FILL_W{1'b0}}, count_reg};
    assign m_valid_next = cap || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pass_reg    <= '0;
            pend_reg    <= 1'b0;
            sort_en_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                sort_en_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (cap) begin
            m_data_reg <= {status_reg, is_empty_q, count_ext[FILL_W-1:0], back_val, front_val};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("Entry count exceeds the queue depth.");

    a_sort_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SORT) |-> !s_tready)
        else $error("Input accepted while a sort is running.");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[69]) |-> (m_tdata[63:0] == 64'd0))
        else $error("Empty result carries nonzero front or back value.");

    a_sort_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SORT && pass_reg == LAST_PASS) |=> (pend_reg && state_reg == S_IDLE))
        else $error("Sort finished without posting a result.");

endmodule

`default_nettype wire
